FILE: rtl/jitter_buffer_reorder_unit_macros.svh
// Assertion macros for the jitter buffer
`ifndef JITTER_BUFFER_REORDER_UNIT_MACROS_SVH
`define JITTER_BUFFER_REORDER_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define JBR_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("jbr check failed");
// next-cycle implication
`define JBR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("jbr check failed");
`endif

FILE: rtl/jbr_pkg.sv
// -----------------------------------------------------------------------------
// jbr_pkg
// Types, codes and constants for the reordering jitter buffer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package jbr_pkg;
   localparam int DEF_SLOT_COUNT  = 16;
   localparam int DEF_MAX_PAYLOAD = 512;
   localparam logic [31:0] WAIT_RESET = 32'd40000;
   localparam logic [15:0] SPF_RESET  = 16'd960;

   localparam logic [2:0] ACT_AUDIO   = 3'd0;
   localparam logic [2:0] ACT_CONTROL = 3'd1;
   localparam logic [2:0] ACT_POP     = 3'd2;
   localparam logic [2:0] ACT_RESET   = 3'd3;
   localparam logic [2:0] ACT_BEGIN   = 3'd4;

   localparam logic [2:0] ST_ACCEPT = 3'd0;
   localparam logic [2:0] ST_LATE   = 3'd1;
   localparam logic [2:0] ST_WINDOW = 3'd2;
   localparam logic [2:0] ST_DUP    = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;
   localparam logic [2:0] ST_NONE   = 3'd5;

   localparam logic [1:0] FK_NONE    = 2'd0;
   localparam logic [1:0] FK_AUDIO   = 2'd1;
   localparam logic [1:0] FK_CONCEAL = 2'd2;

   localparam logic csr_wait_idx = 1'b0;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sequence_req;
      logic [31:0] timestamp;
      logic [31:0] generation;
      logic [15:0] byte_count;
      logic [47:0] time_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  frame_kind;
      logic [5:0]  slot_index;
      logic [31:0] frame_timestamp;
      logic [31:0] frame_generation;
      logic [15:0] frame_size;
      logic [31:0] age_ms;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch request
      logic scan_clear;  // start a table scan
      logic scan_step;   // examine one slot
      logic do_insert;   // decide insert
      logic do_hit;      // consume hit slot
      logic do_conceal;  // decide concealment
      logic do_misc;     // reset, begin, unknown, early pop
      logic div_start;
      logic div_step;
      logic do_play;     // emit audio result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] action;
      logic       scan_last;
      logic       hit_found;
      logic       hit_control;
      logic       pre_reject;
      logic       cursor_valid;
      logic       div_last;
   } stat_type;
endpackage

FILE: rtl/jbr_ctrl.sv
// -----------------------------------------------------------------------------
// jbr_ctrl
// Sequencer: scans the slot table, steps the age multiplier, orders results.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jbr_ctrl
   import jbr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output cmd_type  cmd,
   input  stat_type stat
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_PLAY = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            priority if (stat.action == ACT_AUDIO || stat.action == ACT_CONTROL) begin
               if (stat.pre_reject) begin
                  cmd.do_insert = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (stat.action == ACT_POP && stat.cursor_valid) begin
               cmd.scan_clear = 1'b1;
               state_in = S_SCAN;
            end else begin
               cmd.do_misc = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (stat.action != ACT_POP) begin
               cmd.do_insert = 1'b1;
               state_in = S_IDLE;
            end else if (stat.hit_found && stat.hit_control) begin
               cmd.do_hit = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = S_SCAN;
            end else if (stat.hit_found) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd.do_conceal = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_PLAY;
            end
         end
         S_PLAY: begin
            cmd.do_play = 1'b1;
            cmd.do_hit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

FILE: rtl/jbr_datapath.sv
// -----------------------------------------------------------------------------
// jbr_datapath
// Slot table, cursor, scan registers, age reciprocal multiplier and result
// register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jbr_datapath
   import jbr_pkg::*;
#(
   parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);
   localparam int IW = $clog2(SLOT_COUNT);
   localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);
   localparam logic [15:0] MAXP = 16'(MAX_PAYLOAD);
   // ceil(2^46 / 125): exact floor(y / 125) for y below 2^39
   localparam logic [39:0] RECIP_125 = 40'd562949953422;
   // 1000 * 2^32: elapsed at or above this saturates the age
   localparam logic [47:0] AGE_SAT = 48'd4294967296000;

   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [SLOT_COUNT-1:0] ctl_ff;
   logic [31:0] seq_ff [SLOT_COUNT];
   logic [31:0] ts_ff  [SLOT_COUNT];
   logic [15:0] sz_ff  [SLOT_COUNT];
   logic [47:0] arr_ff [SLOT_COUNT];

   logic        cv_ff, cv_in;
   logic [31:0] exp_ff, exp_in, gen_ff, gen_in;
   logic [31:0] wait_ff;
   logic [15:0] spf_ff;
   req_type     r_ff;

   logic [IW-1:0] idx_ff;
   logic          hit_ff, dup_ff, free_ok_ff, first_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, first_idx_ff;

   logic        sat_ff;
   logic [38:0] y_ff;
   logic [79:0] acc_ff;
   logic [1:0]  dcnt_ff;

   logic    rv_ff;
   rsp_type rsp_ff, rsp_in;

   // effective expected sequence for insert checks
   logic [31:0] eexp;
   assign eexp = cv_ff ? exp_ff : r_ff.sequence_req;

   logic bad_pre;
   assign bad_pre = ((r_ff.action == ACT_AUDIO) &&
                     (r_ff.byte_count == 16'd0 || r_ff.byte_count > MAXP)) ||
                    (r_ff.generation != gen_ff);

   logic [31:0] seq_gap;
   assign seq_gap = r_ff.sequence_req - eexp;

   assign stat.action       = r_ff.action;
   assign stat.scan_last    = (idx_ff == LAST);
   assign stat.hit_found    = hit_ff;
   assign stat.hit_control  = ctl_ff[hit_idx_ff];
   assign stat.pre_reject   = bad_pre;
   assign stat.cursor_valid = cv_ff;
   assign stat.div_last     = (dcnt_ff == 2'd3);

   // current scan slot
   logic        s_used;
   logic [31:0] s_seq;
   assign s_used = used_ff[idx_ff];
   assign s_seq  = seq_ff[idx_ff];

   logic [31:0] fseq;
   assign fseq = seq_ff[first_idx_ff];

   // concealment terms
   logic [47:0] elapsed;
   logic [31:0] missing;
   logic [47:0] back;
   logic        conceal;
   assign elapsed = r_ff.time_us - arr_ff[first_idx_ff];
   assign missing = fseq - exp_ff;
   assign back    = {16'd0, missing} * {32'd0, spf_ff};
   assign conceal = first_ok_ff && (r_ff.time_us >= arr_ff[first_idx_ff]) &&
                    (elapsed >= {16'd0, wait_ff});

   // age / 1000 as (age >> 3) * RECIP_125 >> 46, one 20x20 partial product a cycle
   logic [19:0] mul_a, mul_b;
   logic [39:0] mul_p;
   logic [79:0] mul_term;
   assign mul_a = dcnt_ff[1] ? {1'b0, y_ff[38:20]} : y_ff[19:0];
   assign mul_b = dcnt_ff[0] ? RECIP_125[39:20] : RECIP_125[19:0];
   assign mul_p = mul_a * mul_b;

   always_comb begin
      unique case (dcnt_ff)
         2'd0:    mul_term = {40'd0, mul_p};
         2'd3:    mul_term = {mul_p, 40'd0};
         default: mul_term = {20'd0, mul_p, 20'd0};
      endcase
   end

   logic [47:0] age_now;
   assign age_now = (r_ff.time_us > arr_ff[hit_idx_ff]) ?
                    (r_ff.time_us - arr_ff[hit_idx_ff]) : 48'd0;

   always_comb begin
      used_in = used_ff;
      cv_in   = cv_ff;
      exp_in  = exp_ff;
      gen_in  = gen_ff;
      if (cmd.do_misc) begin
         if (r_ff.action == ACT_RESET) begin
            used_in = '0;
            gen_in  = r_ff.generation;
            cv_in   = 1'b0;
            exp_in  = '0;
         end else if (r_ff.action == ACT_BEGIN) begin
            exp_in = r_ff.sequence_req;
            cv_in  = 1'b1;
         end
      end
      if (cmd.do_insert && !bad_pre) begin
         cv_in  = 1'b1;
         exp_in = eexp;
         if (r_ff.sequence_req >= eexp && seq_gap < 32'(SLOT_COUNT) &&
             !dup_ff && free_ok_ff) begin
            used_in[free_idx_ff] = 1'b1;
         end
      end
      if (cmd.do_hit) begin
         used_in[hit_idx_ff] = 1'b0;
         exp_in = exp_ff + 32'd1;
      end
      if (cmd.do_conceal && conceal) begin
         exp_in = exp_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = ST_NONE;
      if (cmd.do_insert) begin
         priority if (bad_pre) begin
            rsp_in.status = ST_WINDOW;
         end else if (r_ff.sequence_req < eexp) begin
            rsp_in.status = ST_LATE;
         end else if (seq_gap >= 32'(SLOT_COUNT)) begin
            rsp_in.status = ST_WINDOW;
         end else if (dup_ff) begin
            rsp_in.status = ST_DUP;
         end else if (!free_ok_ff) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status     = ST_ACCEPT;
            rsp_in.slot_index = 6'(free_idx_ff);
         end
      end
      if (cmd.do_conceal && conceal) begin
         rsp_in.frame_kind       = FK_CONCEAL;
         rsp_in.frame_timestamp  = ({16'd0, ts_ff[first_idx_ff]} >= back) ?
                                   32'({16'd0, ts_ff[first_idx_ff]} - back) : 32'd0;
         rsp_in.frame_generation = gen_ff;
      end
      if (cmd.do_play) begin
         rsp_in.frame_kind       = FK_AUDIO;
         rsp_in.slot_index       = 6'(hit_idx_ff);
         rsp_in.frame_timestamp  = ts_ff[hit_idx_ff];
         rsp_in.frame_generation = gen_ff;
         rsp_in.frame_size       = sz_ff[hit_idx_ff];
         rsp_in.age_ms           = sat_ff ? 32'hFFFF_FFFF : acc_ff[77:46];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cv_ff   <= 1'b0;
         exp_ff  <= '0;
         gen_ff  <= '0;
         wait_ff <= WAIT_RESET;
         spf_ff  <= SPF_RESET;
         rv_ff   <= 1'b0;
      end else begin
         used_ff <= used_in;
         cv_ff   <= cv_in;
         exp_ff  <= exp_in;
         gen_ff  <= gen_in;
         if (csr_we) begin
            if (csr_index == csr_wait_idx) begin
               wait_ff <= csr_wdata;
            end else begin
               spf_ff <= csr_wdata[15:0];
            end
         end
         rv_ff <= cmd.do_insert || cmd.do_misc || cmd.do_conceal || cmd.do_play;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff <= req_data;
      end
      if (cmd.scan_clear) begin
         idx_ff      <= '0;
         hit_ff      <= 1'b0;
         dup_ff      <= 1'b0;
         free_ok_ff  <= 1'b0;
         first_ok_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (idx_ff != LAST) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (r_ff.action == ACT_POP) begin
            if (s_used && s_seq == exp_ff && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx_ff;
            end
            if (s_used && s_seq > exp_ff && (!first_ok_ff || s_seq < fseq)) begin
               first_ok_ff  <= 1'b1;
               first_idx_ff <= idx_ff;
            end
         end else begin
            if (s_used && s_seq == r_ff.sequence_req) begin
               dup_ff <= 1'b1;
            end
            if (!s_used && !free_ok_ff) begin
               free_ok_ff  <= 1'b1;
               free_idx_ff <= idx_ff;
            end
         end
      end
      if (cmd.do_insert && !bad_pre && used_in[free_idx_ff] && !used_ff[free_idx_ff]) begin
         seq_ff[free_idx_ff] <= r_ff.sequence_req;
         ctl_ff[free_idx_ff] <= (r_ff.action == ACT_CONTROL);
         ts_ff[free_idx_ff]  <= (r_ff.action == ACT_CONTROL) ? 32'd0 : r_ff.timestamp;
         sz_ff[free_idx_ff]  <= (r_ff.action == ACT_CONTROL) ? 16'd0 : r_ff.byte_count;
         arr_ff[free_idx_ff] <= r_ff.time_us;
      end
      if (cmd.div_start) begin
         sat_ff  <= (age_now >= AGE_SAT);
         y_ff    <= age_now[41:3];
         acc_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         acc_ff  <= acc_ff + mul_term;
         dcnt_ff <= dcnt_ff + 2'd1;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: rtl/jitter_buffer_reorder_unit.sv
// -----------------------------------------------------------------------------
// jitter_buffer_reorder_unit
// Reordering jitter buffer: slot table, play cursor and concealment.
// -----------------------------------------------------------------------------
// channel   direction  transfer
// req_      in         start high and busy low
// rsp_      out        rsp_valid high for one cycle
// csr_      in         csr_valid and csr_ready high
//
// Reset, begin, unknown actions, pops without a cursor and inserts failing the
// size or generation check keep busy for the decode state only; other inserts
// decode, scan the table one slot a cycle, then evaluate.
// Pop decodes, then scans and evaluates once per control slot skipped plus
// once; audio play adds the multiply steps and an output state.
// The result strobe rises in the same cycle that busy falls; no stalls.
// Synchronous reset clears the table valid bits at once; no clearing pass.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jitter_buffer_reorder_unit
   import jbr_pkg::*;
#(
   parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   jbr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   jbr_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

FILE: rtl/jbr_checker.sv
// -----------------------------------------------------------------------------
// jbr_checker
// Port-level checks for the jitter buffer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jitter_buffer_reorder_unit_macros.svh"
module jbr_checker
   import jbr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   logic rsp_frame;
   assign rsp_frame = rsp_valid && (rsp_data.frame_kind != FK_NONE);

   `JBR_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `JBR_ASSERT_IMP(a_rsp_ends, clock, reset, rsp_valid, !busy)
   `JBR_ASSERT_IMP(a_kind_status, clock, reset, rsp_frame, rsp_data.status == ST_NONE)
   `JBR_ASSERT_NEXT(a_one_rsp, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind jitter_buffer_reorder_unit jbr_checker u_jbr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
